FILE: design/dhcp_client_lease_fsm_defines.svh
// Assertion macros shared by the lease machine RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef DHCP_CLIENT_LEASE_FSM_DEFINES_SVH
`define DHCP_CLIENT_LEASE_FSM_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DHCL_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DHCL_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DHCL_ASSERT(lbl, clk, rst_n, prop, msg)
`define DHCL_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

FILE: design/dhcl_pkg.sv
// Types and constants of the DHCP client lease machine.
// No dependencies; imported by every module of the block.
package dhcl_pkg;

	localparam int NUM_TIMERS = 3;
	localparam int ADDR_W     = 4;

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_SELECTING  = 3'd1,
		PH_REQUESTING = 3'd2,
		PH_BOUND      = 3'd3,
		PH_RENEWING   = 3'd4,
		PH_REBINDING  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_MSG     = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_START   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		SEND_NONE     = 3'd0,
		SEND_DISCOVER = 3'd1,
		SEND_REQUEST  = 3'd3,
		SEND_RELEASE  = 3'd7
	} send_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_INIT,
		ACT_RELEASE,
		ACT_OFFER,
		ACT_RETRY,
		ACT_ACCEPT,
		ACT_RENEW,
		ACT_REBIND
	} act_t;

	localparam logic [7:0] MSG_OFFER = 8'd2;
	localparam logic [7:0] MSG_ACK   = 8'd5;
	localparam logic [7:0] MSG_NAK   = 8'd6;

	localparam logic [1:0] REG_MIN_HALF_WAIT      = 2'd0;
	localparam logic [1:0] REG_DISCOVER_WAIT      = 2'd1;
	localparam logic [1:0] REG_FIRST_REQUEST_WAIT = 2'd2;
	localparam logic [1:0] REG_LAST_REQUEST_WAIT  = 2'd3;

	localparam logic [15:0] MIN_HALF_WAIT_RST      = 16'd60;
	localparam logic [7:0]  DISCOVER_WAIT_RST      = 8'd1;
	localparam logic [7:0]  FIRST_REQUEST_WAIT_RST = 8'd4;
	localparam logic [7:0]  LAST_REQUEST_WAIT_RST  = 8'd64;

	typedef struct packed {
		logic [15:0] min_half_wait;
		logic [7:0]  discover_wait;
		logic [7:0]  first_request_wait;
		logic [7:0]  last_request_wait;
	} cfg_t;

	typedef struct packed {
		cmd_t        command;
		logic [7:0]  msg_type;
		logic [31:0] offered_ip;
		logic [31:0] server_id;
		logic [31:0] lease_seconds;
	} evt_t;

	typedef struct packed {
		logic        send_valid;
		send_t       send_type;
		logic        send_broadcast;
		logic [31:0] requested_ip;
		logic [31:0] server_ip;
		phase_t      phase;
		logic        lease_accepted;
	} res_t;

endpackage

FILE: design/dhcl_ifs.sv
// Valid/ready channel interfaces of the lease machine: event in, result out.
// No dependencies.
interface dhcl_evt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [7:0]  msg_type;
	logic [31:0] offered_ip;
	logic [31:0] server_id;
	logic [31:0] lease_seconds;

	modport source (output valid, command, msg_type, offered_ip, server_id, lease_seconds,
		input ready);
	modport sink (input valid, command, msg_type, offered_ip, server_id, lease_seconds,
		output ready);
endinterface

interface dhcl_res_if;
	logic        valid;
	logic        ready;
	logic        send_valid;
	logic [2:0]  send_type;
	logic        send_broadcast;
	logic [31:0] requested_ip;
	logic [31:0] server_ip;
	logic [2:0]  phase;
	logic        lease_accepted;

	modport source (output valid, send_valid, send_type, send_broadcast, requested_ip,
		server_ip, phase, lease_accepted, input ready);
	modport sink (input valid, send_valid, send_type, send_broadcast, requested_ip,
		server_ip, phase, lease_accepted, output ready);
endinterface

FILE: design/dhcp_client_lease_fsm.sv
// DHCP client lease machine, top level.
// Channels: evt (sink) carries one event per beat: command, msg_type,
// offered_ip, server_id, lease_seconds. res (source) carries one result
// beat per event: what to transmit now, the phase after the event, and
// whether an ack reloaded the lease timers.
// APB port: four registers at byte addresses 0, 4, 8, 12; pready is tied
// high; writes are meant to happen only while no event is in flight.
// An event taken into the input register is evaluated from it, and its result
// is written to the output register when that register can advance.
// Throughput: one event per cycle while res.ready is high; the state update is a single
// combinational pass between the input register and the output register.
// Stalls: when res.ready is low the output holds; the input register still
// takes one more event, then evt.ready drops until the result is taken.
// Reset: phase idle, addresses zero, all timers disarmed, both registers
// empty, configuration at its defaults.
// Depends on dhcl_pkg, dhcl_ifs, dhcl_cfg and dhcl_core.
module dhcp_client_lease_fsm import dhcl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	dhcl_evt_if.sink          evt,
	dhcl_res_if.source        res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t cfg;
	evt_t evt_s1;
	logic vld_s1;
	res_t res_s2;
	logic vld_s2;
	res_t res_d;
	logic advance;
	logic fire;

	assign advance   = !vld_s2 || res.ready;
	assign fire      = vld_s1 && advance;
	assign evt.ready = !vld_s1 || advance;

	dhcl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dhcl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (fire),
		.evt_s1 (evt_s1),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (evt.ready)
				vld_s1 <= evt.valid;
			if (advance)
				vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			evt_s1.command       <= cmd_t'(evt.command);
			evt_s1.msg_type      <= evt.msg_type;
			evt_s1.offered_ip    <= evt.offered_ip;
			evt_s1.server_id     <= evt.server_id;
			evt_s1.lease_seconds <= evt.lease_seconds;
		end
		if (fire)
			res_s2 <= res_d;
	end

	assign res.valid          = vld_s2;
	assign res.send_valid     = res_s2.send_valid;
	assign res.send_type      = res_s2.send_type;
	assign res.send_broadcast = res_s2.send_broadcast;
	assign res.requested_ip   = res_s2.requested_ip;
	assign res.server_ip      = res_s2.server_ip;
	assign res.phase          = res_s2.phase;
	assign res.lease_accepted = res_s2.lease_accepted;

endmodule

FILE: design/dhcl_cfg.sv
// APB configuration registers of the lease machine.
// Depends on dhcl_pkg.
module dhcl_cfg import dhcl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_half_wait      <= MIN_HALF_WAIT_RST;
			cfg_q.discover_wait      <= DISCOVER_WAIT_RST;
			cfg_q.first_request_wait <= FIRST_REQUEST_WAIT_RST;
			cfg_q.last_request_wait  <= LAST_REQUEST_WAIT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MIN_HALF_WAIT:      cfg_q.min_half_wait      <= pwdata[15:0];
				REG_DISCOVER_WAIT:      cfg_q.discover_wait      <= pwdata[7:0];
				REG_FIRST_REQUEST_WAIT: cfg_q.first_request_wait <= pwdata[7:0];
				REG_LAST_REQUEST_WAIT:  cfg_q.last_request_wait  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MIN_HALF_WAIT:      prdata = {16'd0, cfg_q.min_half_wait};
			REG_DISCOVER_WAIT:      prdata = {24'd0, cfg_q.discover_wait};
			REG_FIRST_REQUEST_WAIT: prdata = {24'd0, cfg_q.first_request_wait};
			REG_LAST_REQUEST_WAIT:  prdata = {24'd0, cfg_q.last_request_wait};
			default:                prdata = 32'd0;
		endcase
	end

endmodule

FILE: design/dhcl_core.sv
// Lease state, timers and the single-pass event update of the lease machine.
// Depends on dhcl_pkg and dhcp_client_lease_fsm_defines.svh.
`include "dhcp_client_lease_fsm_defines.svh"
module dhcl_core import dhcl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic fire,
	input  evt_t evt_s1,
	output res_t res
);

	phase_t      phase_q, phase_d;
	logic [31:0] client_q, client_d;
	logic [31:0] server_q, server_d;
	logic [7:0]  retry_q, retry_d;
	logic [31:0] timer_q [NUM_TIMERS];
	logic [31:0] timer_d [NUM_TIMERS];
	logic [31:0] tbase [NUM_TIMERS];

	logic                  tick;
	logic [NUM_TIMERS-1:0] expired;
	logic                  ev0, ev1, ev2;
	logic [8:0]            retry_next;
	logic                  retry_fail;
	logic                  offer_fail;
	logic                  offer_seen;
	logic [34:0]           lease_x7;
	logic [31:0]           renew_wait;
	logic [31:0]           rebind_wait;
	act_t                  act;

	function automatic logic [31:0] half_floor(input logic [31:0] t, input logic [15:0] fl);
		logic [31:0] h;
		h = {1'b0, t[31:1]};
		if (h < {16'd0, fl})
			h = {16'd0, fl};
		return h;
	endfunction

	assign tick = (evt_s1.command == CMD_TICK);

	always_comb begin
		for (int i = 0; i < NUM_TIMERS; i++) begin
			expired[i] = tick && (timer_q[i] == 32'd1);
			tbase[i]   = (tick && timer_q[i] != 32'd0) ? timer_q[i] - 32'd1 : timer_q[i];
		end
	end

	// highest-numbered expiry wins
	assign ev2 = expired[2];
	assign ev1 = expired[1] && !expired[2];
	assign ev0 = expired[0] && !expired[1] && !expired[2];

	assign retry_next  = {retry_q, 1'b0};
	assign retry_fail  = retry_next > {1'b0, cfg.last_request_wait};
	assign offer_fail  = cfg.first_request_wait > cfg.last_request_wait;
	assign lease_x7    = {evt_s1.lease_seconds, 3'b000} - {3'b000, evt_s1.lease_seconds};
	assign renew_wait  = half_floor(tbase[1], cfg.min_half_wait);
	assign rebind_wait = half_floor(tbase[2], cfg.min_half_wait);

	// event decode
	always_comb begin
		act        = ACT_NONE;
		offer_seen = 1'b0;
		case (evt_s1.command)
			CMD_START: act = ACT_INIT;
			CMD_RELEASE: begin
				if (phase_q != PH_IDLE)
					act = ACT_RELEASE;
			end
			CMD_MSG: begin
				case (phase_q)
					PH_SELECTING: begin
						if (evt_s1.msg_type == MSG_OFFER) begin
							offer_seen = 1'b1;
							act        = offer_fail ? ACT_INIT : ACT_OFFER;
						end
					end
					PH_REQUESTING, PH_RENEWING, PH_REBINDING: begin
						if (evt_s1.msg_type == MSG_ACK)
							act = ACT_ACCEPT;
						else if (evt_s1.msg_type == MSG_NAK)
							act = ACT_INIT;
					end
					default: ;
				endcase
			end
			CMD_TICK: begin
				case (phase_q)
					PH_SELECTING: begin
						if (ev0)
							act = ACT_INIT;
					end
					PH_REQUESTING: begin
						if (ev0)
							act = retry_fail ? ACT_INIT : ACT_RETRY;
					end
					PH_BOUND, PH_RENEWING: begin
						if (ev0)
							act = ACT_RENEW;
						else if (ev1)
							act = ACT_REBIND;
						else if (ev2)
							act = ACT_INIT;
					end
					PH_REBINDING: begin
						if (ev0)
							act = ACT_REBIND;
						else if (ev2)
							act = ACT_INIT;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		phase_d  = phase_q;
		client_d = client_q;
		server_d = server_q;
		retry_d  = retry_q;
		timer_d  = tbase;
		if (offer_seen)
			retry_d = cfg.first_request_wait;
		case (act)
			ACT_INIT: begin
				client_d   = 32'd0;
				server_d   = 32'd0;
				timer_d[0] = {24'd0, cfg.discover_wait};
				timer_d[1] = 32'd0;
				timer_d[2] = 32'd0;
				phase_d    = PH_SELECTING;
			end
			ACT_RELEASE: begin
				client_d   = 32'd0;
				server_d   = 32'd0;
				timer_d[0] = 32'd0;
				timer_d[1] = 32'd0;
				timer_d[2] = 32'd0;
				phase_d    = PH_IDLE;
			end
			ACT_OFFER: begin
				client_d   = evt_s1.offered_ip;
				server_d   = evt_s1.server_id;
				timer_d[0] = {24'd0, cfg.first_request_wait};
				phase_d    = PH_REQUESTING;
			end
			ACT_RETRY: begin
				retry_d    = retry_next[7:0];
				timer_d[0] = {24'd0, retry_next[7:0]};
				phase_d    = PH_REQUESTING;
			end
			ACT_ACCEPT: begin
				timer_d[0] = {1'b0, evt_s1.lease_seconds[31:1]};
				timer_d[1] = lease_x7[34:3];
				timer_d[2] = evt_s1.lease_seconds;
				phase_d    = PH_BOUND;
			end
			ACT_RENEW: begin
				timer_d[0] = renew_wait;
				phase_d    = PH_RENEWING;
			end
			ACT_REBIND: begin
				timer_d[0] = rebind_wait;
				phase_d    = PH_REBINDING;
			end
			default: ;
		endcase
	end

	// result
	always_comb begin
		res                = '0;
		res.phase          = phase_d;
		res.lease_accepted = (act == ACT_ACCEPT);
		case (act)
			ACT_INIT: begin
				res.send_valid     = 1'b1;
				res.send_type      = SEND_DISCOVER;
				res.send_broadcast = 1'b1;
			end
			ACT_RELEASE: begin
				res.send_valid   = 1'b1;
				res.send_type    = SEND_RELEASE;
				res.requested_ip = client_q;
				res.server_ip    = server_q;
			end
			ACT_OFFER: begin
				res.send_valid     = 1'b1;
				res.send_type      = SEND_REQUEST;
				res.send_broadcast = 1'b1;
				res.requested_ip   = evt_s1.offered_ip;
				res.server_ip      = evt_s1.server_id;
			end
			ACT_RETRY, ACT_REBIND: begin
				res.send_valid     = 1'b1;
				res.send_type      = SEND_REQUEST;
				res.send_broadcast = 1'b1;
				res.requested_ip   = client_q;
				res.server_ip      = server_q;
			end
			ACT_RENEW: begin
				res.send_valid   = 1'b1;
				res.send_type    = SEND_REQUEST;
				res.requested_ip = client_q;
				res.server_ip    = server_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			client_q <= 32'd0;
			server_q <= 32'd0;
			retry_q  <= FIRST_REQUEST_WAIT_RST;
			for (int i = 0; i < NUM_TIMERS; i++)
				timer_q[i] <= 32'd0;
		end else if (fire) begin
			phase_q  <= phase_d;
			client_q <= client_d;
			server_q <= server_d;
			retry_q  <= retry_d;
			for (int i = 0; i < NUM_TIMERS; i++)
				timer_q[i] <= timer_d[i];
		end
	end

	`DHCL_ASSERT(a_idle_disarmed, clk, arst_n, phase_q == PH_IDLE |-> timer_q[0] == 32'd0 && timer_q[1] == 32'd0 && timer_q[2] == 32'd0, "timer armed while idle")
	`DHCL_ASSERT(a_accept_bound, clk, arst_n, fire && act == ACT_ACCEPT |=> phase_q == PH_BOUND, "accepted lease did not bind")
	`DHCL_ASSERT(a_release_clears, clk, arst_n, fire && act == ACT_RELEASE |=> phase_q == PH_IDLE && client_q == 32'd0 && server_q == 32'd0, "release left state behind")
	`DHCL_ASSERT_NEVER(a_quiet_payload, clk, arst_n, !res.send_valid && (res.send_type != SEND_NONE || res.requested_ip != 32'd0 || res.server_ip != 32'd0), "payload without send")

endmodule

FILE: test/dhcl_lease_checker.sv
// Checker for the DHCP client lease machine: watches the event, result and APB
// channels, predicts one result beat per accepted event beat and compares them.
// Depends on dhcl_pkg and dhcl_ifs.
module dhcl_lease_checker import dhcl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	dhcl_evt_if               evt,
	dhcl_res_if               res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	output int                fail_count,
	output int                pending,
	output int                checked,
	output logic [5:0]        phases_seen
);

	cfg_t        cfg;
	phase_t      st_phase;
	logic [31:0] st_cli;
	logic [31:0] st_srv;
	logic [7:0]  st_retry;
	logic [31:0] st_tmr [NUM_TIMERS];
	res_t        r;

	res_t        due_results[$];
	res_t        got;
	res_t        want;
	evt_t        ev;
	int          n_bad;
	int          n_done;
	logic [5:0]  seen_mask;

	function automatic void emit_msg(send_t kind, logic bc, logic [31:0] rip, logic [31:0] sip);
		r.send_valid     = 1'b1;
		r.send_type      = kind;
		r.send_broadcast = bc;
		r.requested_ip   = rip;
		r.server_ip      = sip;
	endfunction

	function automatic void drop_lease();
		st_cli = '0;
		st_srv = '0;
		for (int i = 0; i < NUM_TIMERS; i++)
			st_tmr[i] = '0;
	endfunction

	function automatic void rediscover();
		drop_lease();
		st_tmr[0] = {24'd0, cfg.discover_wait};
		st_phase  = PH_SELECTING;
		emit_msg(SEND_DISCOVER, 1'b1, '0, '0);
	endfunction

	function automatic void request_now();
		st_tmr[0] = {24'd0, st_retry};
		st_phase  = PH_REQUESTING;
		emit_msg(SEND_REQUEST, 1'b1, st_cli, st_srv);
	endfunction

	function automatic void begin_request();
		st_retry = cfg.first_request_wait;
		if (st_retry > cfg.last_request_wait)
			rediscover();
		else
			request_now();
	endfunction

	function automatic void retry_request();
		logic [8:0] nxt;
		nxt = {st_retry, 1'b0};
		if (nxt > {1'b0, cfg.last_request_wait}) begin
			rediscover();
		end else begin
			st_retry = nxt[7:0];
			request_now();
		end
	endfunction

	function automatic void bind_lease(logic [31:0] lease);
		logic [34:0] scaled;
		scaled = {3'd0, lease} * 35'd7;
		st_tmr[0] = lease >> 1;
		st_tmr[1] = scaled[34:3];
		st_tmr[2] = lease;
		st_phase  = PH_BOUND;
		r.lease_accepted = 1'b1;
	endfunction

	function automatic logic [31:0] half_of(int idx);
		logic [31:0] h;
		h = st_tmr[idx] >> 1;
		if (h < {16'd0, cfg.min_half_wait})
			h = {16'd0, cfg.min_half_wait};
		return h;
	endfunction

	function automatic void renew();
		st_phase  = PH_RENEWING;
		st_tmr[0] = half_of(1);
		emit_msg(SEND_REQUEST, 1'b0, st_cli, st_srv);
	endfunction

	function automatic void rebind();
		st_phase  = PH_REBINDING;
		st_tmr[0] = half_of(2);
		emit_msg(SEND_REQUEST, 1'b1, st_cli, st_srv);
	endfunction

	function automatic void second_tick();
		int fired = -1;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			if (st_tmr[i] != 0) begin
				st_tmr[i] = st_tmr[i] - 1;
				if (st_tmr[i] == 0)
					fired = i;
			end
		end
		if (fired < 0)
			return;
		case (st_phase)
			PH_SELECTING: begin
				if (fired == 0)
					rediscover();
			end
			PH_REQUESTING: begin
				if (fired == 0)
					retry_request();
			end
			PH_BOUND, PH_RENEWING: begin
				if (fired == 0)
					renew();
				else if (fired == 1)
					rebind();
				else
					rediscover();
			end
			PH_REBINDING: begin
				if (fired == 0)
					rebind();
				else if (fired == 2)
					rediscover();
			end
			default: ;
		endcase
	endfunction

	function automatic void take_message(evt_t e);
		case (st_phase)
			PH_SELECTING: begin
				if (e.msg_type == MSG_OFFER) begin
					st_cli = e.offered_ip;
					st_srv = e.server_id;
					begin_request();
				end
			end
			PH_REQUESTING, PH_RENEWING, PH_REBINDING: begin
				if (e.msg_type == MSG_ACK)
					bind_lease(e.lease_seconds);
				else if (e.msg_type == MSG_NAK)
					rediscover();
			end
			default: ;
		endcase
	endfunction

	function automatic res_t lease_event(evt_t e);
		r = '0;
		case (e.command)
			CMD_TICK:    second_tick();
			CMD_MSG:     take_message(e);
			CMD_RELEASE: begin
				if (st_phase != PH_IDLE) begin
					emit_msg(SEND_RELEASE, 1'b0, st_cli, st_srv);
					drop_lease();
					st_phase = PH_IDLE;
				end
			end
			default:     rediscover();
		endcase
		r.phase = st_phase;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.min_half_wait      = MIN_HALF_WAIT_RST;
			cfg.discover_wait      = DISCOVER_WAIT_RST;
			cfg.first_request_wait = FIRST_REQUEST_WAIT_RST;
			cfg.last_request_wait  = LAST_REQUEST_WAIT_RST;
			st_phase = PH_IDLE;
			st_retry = FIRST_REQUEST_WAIT_RST;
			drop_lease();
			due_results.delete();
			n_bad     = 0;
			n_done    = 0;
			seen_mask = '0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_MIN_HALF_WAIT:      cfg.min_half_wait      = pwdata[15:0];
					REG_DISCOVER_WAIT:      cfg.discover_wait      = pwdata[7:0];
					REG_FIRST_REQUEST_WAIT: cfg.first_request_wait = pwdata[7:0];
					REG_LAST_REQUEST_WAIT:  cfg.last_request_wait  = pwdata[7:0];
					default: ;
				endcase
			end
			if (res.valid && res.ready) begin
				got.send_valid     = res.send_valid;
				got.send_type      = send_t'(res.send_type);
				got.send_broadcast = res.send_broadcast;
				got.requested_ip   = res.requested_ip;
				got.server_ip      = res.server_ip;
				got.phase          = phase_t'(res.phase);
				got.lease_accepted = res.lease_accepted;
				if (due_results.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("chk: result beat with no event outstanding, phase %0d",
							res.phase);
				end else begin
					want = due_results.pop_front();
					n_done++;
					if (got.send_valid !== want.send_valid ||
						got.send_type !== want.send_type ||
						got.send_broadcast !== want.send_broadcast ||
						got.requested_ip !== want.requested_ip ||
						got.server_ip !== want.server_ip ||
						got.phase !== want.phase ||
						got.lease_accepted !== want.lease_accepted) begin
						n_bad++;
						if (n_bad <= 10) begin
							$display("chk: mismatch (exp/got) valid %0d/%0d type %0d/%0d bcast %0d/%0d",
								want.send_valid, got.send_valid, want.send_type,
								got.send_type, want.send_broadcast, got.send_broadcast);
							$display("chk:   ip %h/%h server %h/%h phase %0d/%0d accepted %0d/%0d",
								want.requested_ip, got.requested_ip, want.server_ip,
								got.server_ip, want.phase, got.phase,
								want.lease_accepted, got.lease_accepted);
						end
					end
				end
			end
			if (evt.valid && evt.ready) begin
				ev.command       = cmd_t'(evt.command);
				ev.msg_type      = evt.msg_type;
				ev.offered_ip    = evt.offered_ip;
				ev.server_id     = evt.server_id;
				ev.lease_seconds = evt.lease_seconds;
				want = lease_event(ev);
				seen_mask[want.phase] = 1'b1;
				due_results.push_back(want);
			end
		end
		fail_count  <= n_bad;
		pending     <= due_results.size();
		checked     <= n_done;
		phases_seen <= seen_mask;
	end

endmodule

FILE: test/tb.sv
// Top of the lease machine testbench: clock, reset, event and APB stimulus,
// result-side back-pressure and the verdict. Checking is done by dhcl_lease_checker.
// Depends on dhcl_pkg, dhcl_ifs, dhcp_client_lease_fsm and dhcl_lease_checker.
module tb;
	import dhcl_pkg::*;

	localparam int LIMIT = 300000;

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	int                fail_count;
	int                pending;
	int                checked;
	logic [5:0]        phases_seen;

	bit                quiet    = 1'b0;
	bit                hold_req = 1'b0;
	bit                hold_done;
	int                n_events = 0;
	int                n_cfg    = 0;
	int                cycles   = 0;
	int                event_goal = 0;

	always #2 clk = ~clk;

	dhcl_evt_if evt ();
	dhcl_res_if res ();

	dhcp_client_lease_fsm uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.evt     (evt),
		.res     (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	dhcl_lease_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.evt         (evt),
		.res         (res),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.fail_count  (fail_count),
		.pending     (pending),
		.checked     (checked),
		.phases_seen (phases_seen)
	);

	task automatic send_event(cmd_t c, logic [7:0] mt, logic [31:0] ip, logic [31:0] sid,
		logic [31:0] lease);
		while (!quiet && $urandom_range(99) < 29) begin
			evt.valid <= 1'b0;
			@(posedge clk);
		end
		evt.valid         <= 1'b1;
		evt.command       <= c;
		evt.msg_type      <= mt;
		evt.offered_ip    <= ip;
		evt.server_id     <= sid;
		evt.lease_seconds <= lease;
		@(posedge clk);
		while (!evt.ready)
			@(posedge clk);
		n_events++;
	endtask

	task automatic tick();
		send_event(CMD_TICK, 8'($urandom_range(255)), $urandom, $urandom, $urandom);
	endtask

	task automatic bare(cmd_t c);
		send_event(c, 8'($urandom_range(255)), $urandom, $urandom, $urandom);
	endtask

	task automatic msg(logic [7:0] mt, logic [31:0] ip, logic [31:0] sid, logic [31:0] lease);
		send_event(CMD_MSG, mt, ip, sid, lease);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		evt.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_type();
		case ($urandom_range(5))
			0:       return MSG_OFFER;
			1:       return MSG_ACK;
			2:       return MSG_NAK;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic noise_event();
		send_event(cmd_t'($urandom_range(3)), pick_type(), $urandom, $urandom, $urandom);
	endtask

	// start, offer, ack (or sometimes nak), then let the lease age with occasional renew/nak/release
	task automatic lease_session();
		logic [31:0] lease;
		int          k;
		int          act;
		bit          stop;
		bare(CMD_START);
		repeat ($urandom_range(0, 2)) tick();
		if ($urandom_range(99) < 15)
			repeat ($urandom_range(1, 6)) tick();
		msg(MSG_OFFER, $urandom, $urandom, $urandom);
		repeat ($urandom_range(0, 3)) tick();
		if ($urandom_range(99) < 10) begin
			msg(MSG_NAK, $urandom, $urandom, $urandom);
		end else begin
			act = $urandom_range(99);
			lease = (act < 5) ? 32'd0 : (act < 12) ? $urandom : 32'($urandom_range(1, 120));
			msg(MSG_ACK, $urandom, $urandom, lease);
			stop = 1'b0;
			for (int round = 0; round < 3 && !stop && n_events < event_goal; round++) begin
				k = (lease < 200) ? $urandom_range(0, lease + 4) : $urandom_range(0, 40);
				while (k > 0 && n_events < event_goal) begin
					tick();
					k--;
				end
				act = $urandom_range(99);
				if (act < 30) begin
					lease = 32'($urandom_range(1, 120));
					msg(MSG_ACK, $urandom, $urandom, lease);
				end else if (act < 40) begin
					msg(MSG_NAK, $urandom, $urandom, $urandom);
					stop = 1'b1;
				end else if (act < 55) begin
					bare(CMD_RELEASE);
					stop = 1'b1;
				end else begin
					stop = 1'b1;
				end
			end
		end
	endtask

	task automatic random_events(int n);
		event_goal = n_events + n;
		while (n_events < event_goal) begin
			if ($urandom_range(99) < 25)
				noise_event();
			else
				lease_session();
		end
	endtask

	task automatic run_phase(logic [15:0] mh, logic [7:0] dw, logic [7:0] fw, logic [7:0] lw,
		int n_items, bit calm, bit hold);
		reg_write(REG_MIN_HALF_WAIT, {16'd0, mh});
		reg_write(REG_DISCOVER_WAIT, {24'd0, dw});
		reg_write(REG_FIRST_REQUEST_WAIT, {24'd0, fw});
		reg_write(REG_LAST_REQUEST_WAIT, {24'd0, lw});
		n_cfg++;
		quiet = calm;
		random_events(n_items / 2);
		quiet = 1'b0;
		if (hold)
			hold_req <= 1'b1;
		random_events(n_items - n_items / 2);
		drain();
	endtask

	task automatic directed();
		tick();
		bare(CMD_RELEASE);
		msg(MSG_OFFER, $urandom, $urandom, $urandom);
		bare(CMD_START);
		msg(MSG_ACK, $urandom, $urandom, 32'd100);
		tick();
		msg(MSG_OFFER, 32'hFFFF_FFFF, 32'h0, $urandom);
		msg(8'hFF, $urandom, $urandom, $urandom);
		repeat (4) tick();
		msg(MSG_NAK, $urandom, $urandom, $urandom);
		msg(MSG_OFFER, 32'h0, 32'hFFFF_FFFF, $urandom);
		msg(MSG_ACK, $urandom, $urandom, 32'hFFFF_FFFF);
		bare(CMD_RELEASE);
		bare(CMD_START);
		msg(MSG_OFFER, $urandom, $urandom, $urandom);
		msg(MSG_ACK, $urandom, $urandom, 32'd3);
		tick();
		tick();
		msg(MSG_ACK, $urandom, $urandom, 32'd2);
		tick();
		tick();
		msg(MSG_OFFER, $urandom, $urandom, $urandom);
		msg(MSG_ACK, $urandom, $urandom, 32'd0);
	endtask

	initial begin
		res.ready = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				res.ready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			res.ready <= quiet || $urandom_range(99) >= 29;
		end
	end

	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: FAIL");
		$finish;
	end

	initial begin
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		evt.valid         = 1'b0;
		evt.command       = CMD_TICK;
		evt.msg_type      = '0;
		evt.offered_ip    = '0;
		evt.server_id     = '0;
		evt.lease_seconds = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		directed();
		drain();

		run_phase(16'd1, 8'd1, 8'd1, 8'd255, 450, 1'b0, 1'b1);
		run_phase(16'hFFFF, 8'hFF, 8'hFF, 8'd1, 200, 1'b0, 1'b0);
		run_phase(16'($urandom_range(1, 200)), 8'($urandom_range(1, 8)),
			8'($urandom_range(1, 16)), 8'($urandom_range(16, 255)), 500, 1'b0, 1'b0);
		run_phase(MIN_HALF_WAIT_RST, DISCOVER_WAIT_RST, FIRST_REQUEST_WAIT_RST,
			LAST_REQUEST_WAIT_RST, 500, 1'b1, 1'b0);

		$display("summary: %0d events, %0d result beats checked, %0d register settings",
			n_events, checked, n_cfg);
		$display("summary: phases reached %b (bit per phase), %0d cycles, %0d failures",
			phases_seen, cycles, fail_count);
		if (fail_count == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
